// ----- rtl/rmpl_pkg.sv -----
// Shared types and constants for the motor command ramp limiter.
// Used by the register bank, the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps

package rmpl_pkg;

   // Q2.14 plus and minus one, at the widths the datapath needs.
   localparam logic signed [15:0] Q_ONE       = 16'sd16384;
   localparam logic signed [15:0] Q_NEG_ONE   = -16'sd16384;
   localparam logic signed [16:0] Q_ONE_W     = 17'sd16384;
   localparam logic signed [16:0] Q_NEG_ONE_W = -17'sd16384;

   // Command codes carried in the cmd field of a command beat.
   localparam logic CMD_UPDATE   = 1'b0;
   localparam logic CMD_OVERRIDE = 1'b1;

   // Register reset values.
   localparam logic [14:0] EPSILON_RESET   = 15'd164;
   localparam logic [14:0] MAX_DELTA_RESET = 15'd8192;
   localparam logic [7:0]  TICKS_RESET     = 8'd10;

   // Register indexes (byte address divided by four).
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] CSR_EPSILON   = 2'd0;
   localparam logic [1:0] CSR_MAX_DELTA = 2'd1;
   localparam logic [1:0] CSR_TICKS     = 2'd2;

   // Serial divider: one quotient bit per cycle over a 16-bit magnitude.
   localparam int unsigned DIV_STEPS = 16;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_UPDATE,
      ST_RESPOND
   } rmpl_state_type;

   typedef struct packed {
      logic [14:0] epsilon;
      logic [14:0] max_delta;
      logic [7:0]  ticks;
   } rmpl_cfg_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic div_step;
      logic step_load;
      logic out_load;
   } rmpl_ctrl_type;

   typedef struct packed {
      logic ramp;
      logic div_last;
      logic out_free;
   } rmpl_status_type;

   function automatic logic signed [15:0] sat_one(input logic signed [16:0] x);
      logic signed [15:0] r;
      if (x > Q_ONE_W) begin
         r = Q_ONE;
      end else if (x < Q_NEG_ONE_W) begin
         r = Q_NEG_ONE;
      end else begin
         r = x[15:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/rmpl_req_if.sv -----
// Command channel interface: valid/ready handshake with the command beat.
// No dependencies.
`timescale 1ns / 1ps

interface rmpl_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [15:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ----- rtl/rmpl_rsp_if.sv -----
// Result channel interface: valid/ready handshake with the result beat.
// No dependencies.
`timescale 1ns / 1ps

interface rmpl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] drive_value;
   logic signed [15:0] target_value;
   logic signed [16:0] step_delta;
   logic               jump_ready;

   modport source (output valid, output drive_value, output target_value,
                   output step_delta, output jump_ready, input ready);
   modport sink   (input valid, input drive_value, input target_value,
                   input step_delta, input jump_ready, output ready);
endinterface

// ----- rtl/rmpl_csr.sv -----
// Configuration register bank behind an APB-style port.
// Depends on rmpl_pkg.
`timescale 1ns / 1ps

module rmpl_csr
   import rmpl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output rmpl_cfg_type          cfg
);

   logic [14:0] epsilon_ff, epsilon_in;
   logic [14:0] max_delta_ff, max_delta_in;
   logic [7:0]  ticks_ff, ticks_in;
   logic        wr_en;
   logic [1:0]  index;

   assign index      = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      epsilon_in   = epsilon_ff;
      max_delta_in = max_delta_ff;
      ticks_in     = ticks_ff;
      if (wr_en) begin
         unique case (index)
            CSR_EPSILON:   epsilon_in   = csr_pwdata[14:0];
            CSR_MAX_DELTA: max_delta_in = csr_pwdata[14:0];
            CSR_TICKS:     ticks_in     = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_EPSILON:   csr_prdata = {17'd0, epsilon_ff};
         CSR_MAX_DELTA: csr_prdata = {17'd0, max_delta_ff};
         CSR_TICKS:     csr_prdata = {24'd0, ticks_ff};
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff   <= EPSILON_RESET;
         max_delta_ff <= MAX_DELTA_RESET;
         ticks_ff     <= TICKS_RESET;
      end else begin
         epsilon_ff   <= epsilon_in;
         max_delta_ff <= max_delta_in;
         ticks_ff     <= ticks_in;
      end
   end

   assign cfg.epsilon   = epsilon_ff;
   assign cfg.max_delta = max_delta_ff;
   assign cfg.ticks     = ticks_ff;

endmodule

// ----- rtl/rmpl_ctrl.sv -----
// Controller state machine: sequences capture, evaluation, division and the result beat.
// Depends on rmpl_pkg.
`timescale 1ns / 1ps

module rmpl_ctrl
   import rmpl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  rmpl_status_type status,
   output rmpl_ctrl_type   ctrl
);

   rmpl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_EVAL;
         ST_EVAL:    state_in = status.ramp ? ST_DIVIDE : ST_RESPOND;
         ST_DIVIDE:  if (status.div_last) state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_RESPOND;
         ST_RESPOND: if (status.out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      ctrl.capture   = 1'b0;
      ctrl.eval      = 1'b0;
      ctrl.div_step  = 1'b0;
      ctrl.step_load = 1'b0;
      ctrl.out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            ctrl.capture = req_valid;
         end
         ST_EVAL:    ctrl.eval      = 1'b1;
         ST_DIVIDE:  ctrl.div_step  = 1'b1;
         ST_UPDATE:  ctrl.step_load = 1'b1;
         ST_RESPOND: ctrl.out_load  = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/rmpl_datapath.sv -----
// Datapath: ramp state, decision logic, serial step divider and the output register.
// Depends on rmpl_pkg.
`timescale 1ns / 1ps

module rmpl_datapath
   import rmpl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  rmpl_cfg_type       cfg,
   input  rmpl_ctrl_type      ctrl,
   output rmpl_status_type    status,
   input  logic               req_cmd,
   input  logic signed [15:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_drive_value,
   output logic signed [15:0] rsp_target_value,
   output logic signed [16:0] rsp_step_delta,
   output logic               rsp_jump_ready
);

   // Captured command beat.
   logic               cmd_ff, cmd_in;
   logic signed [15:0] val_ff, val_in;

   // Ramp state.
   logic signed [15:0] drive_ff, drive_in;
   logic signed [15:0] target_ff, target_in;
   logic signed [16:0] step_ff, step_in;
   logic [7:0]         tick_ff, tick_in;
   logic               ready_ff, ready_in;

   // Divider.
   logic [15:0]          quo_ff, quo_in;
   logic [7:0]           rem_ff, rem_in;
   logic [7:0]           divisor_ff, divisor_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // Output register.
   logic               out_valid_ff, out_valid_in;
   logic signed [15:0] out_drive_ff, out_drive_in;
   logic signed [15:0] out_target_ff, out_target_in;
   logic signed [16:0] out_step_ff, out_step_in;
   logic               out_ready_ff, out_ready_in;

   logic signed [16:0] diff;
   logic [16:0]        mag;
   logic               pass;
   logic signed [16:0] move;
   logic signed [16:0] lim;
   logic signed [16:0] move_lim;
   logic signed [15:0] new_target;
   logic signed [16:0] span;
   logic [16:0]        span_mag;
   logic signed [15:0] stepped;
   logic [8:0]         trial;
   logic               trial_ge;
   logic [8:0]         trial_sub;

   always_comb begin
      diff     = 17'(val_ff) - 17'(drive_ff);
      mag      = diff[16] ? 17'(-diff) : 17'(diff);
      pass     = mag < {2'b00, cfg.epsilon};
      move     = 17'(val_ff) - 17'(target_ff);
      lim      = {2'b00, cfg.max_delta};
      if (move > lim) begin
         move_lim = lim;
      end else if (move < -lim) begin
         move_lim = -lim;
      end else begin
         move_lim = move;
      end
      new_target = sat_one(17'(target_ff) + move_lim);
      span       = 17'(new_target) - 17'(drive_ff);
      span_mag   = span[16] ? 17'(-span) : 17'(span);
      stepped    = sat_one(17'(drive_ff) + step_ff);
      trial      = {rem_ff, quo_ff[15]};
      trial_ge   = trial >= {1'b0, divisor_ff};
      trial_sub  = trial - {1'b0, divisor_ff};
   end

   assign status.ramp     = (cmd_ff == CMD_UPDATE) && !pass && ready_ff;
   assign status.div_last = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      drive_in      = drive_ff;
      target_in     = target_ff;
      step_in       = step_ff;
      tick_in       = tick_ff;
      ready_in      = ready_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      out_drive_in  = out_drive_ff;
      out_target_in = out_target_ff;
      out_step_in   = out_step_ff;
      out_ready_in  = out_ready_ff;

      if (ctrl.capture) begin
         cmd_in = req_cmd;
         val_in = sat_one(17'(req_value));
      end

      if (ctrl.eval) begin
         if (cmd_ff == CMD_OVERRIDE) begin
            drive_in  = val_ff;
            target_in = val_ff;
            ready_in  = 1'b1;
            tick_in   = 8'd0;
         end else if (pass) begin
            drive_in = val_ff;
            ready_in = 1'b1;
         end else if (ready_ff) begin
            // New ramp: the step itself is filled in once the divider finishes.
            target_in  = new_target;
            ready_in   = 1'b0;
            tick_in    = 8'd0;
            quo_in     = span_mag[15:0];
            rem_in     = 8'd0;
            neg_in     = span[16];
            divisor_in = (cfg.ticks == 8'd0) ? 8'd1 : cfg.ticks;
            cnt_in     = '0;
         end else if (tick_ff < cfg.ticks) begin
            drive_in = stepped;
            tick_in  = 8'(tick_ff + 8'd1);
         end else begin
            ready_in = 1'b1;
         end
      end

      if (ctrl.div_step) begin
         rem_in = trial_ge ? trial_sub[7:0] : trial[7:0];
         quo_in = {quo_ff[14:0], trial_ge};
         cnt_in = DIV_CNT_W'(cnt_ff + 1'b1);
      end

      // Truncation toward zero: divide the magnitude, then restore the sign.
      if (ctrl.step_load) begin
         step_in = neg_ff ? 17'(-{1'b0, quo_ff}) : {1'b0, quo_ff};
      end

      if (ctrl.out_load) begin
         out_drive_in  = drive_ff;
         out_target_in = target_ff;
         out_step_in   = step_ff;
         out_ready_in  = ready_ff;
      end
   end

   always_comb begin
      if (ctrl.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff     <= '0;
         target_ff    <= '0;
         step_ff      <= '0;
         tick_ff      <= '0;
         ready_ff     <= 1'b1;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         drive_ff     <= drive_in;
         target_ff    <= target_in;
         step_ff      <= step_in;
         tick_ff      <= tick_in;
         ready_ff     <= ready_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      neg_ff        <= neg_in;
      out_drive_ff  <= out_drive_in;
      out_target_ff <= out_target_in;
      out_step_ff   <= out_step_in;
      out_ready_ff  <= out_ready_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_drive_value  = out_drive_ff;
   assign rsp_target_value = out_target_ff;
   assign rsp_step_delta   = out_step_ff;
   assign rsp_jump_ready   = out_ready_ff;

endmodule

// ----- rtl/motor_command_ramp_limiter_unit.sv -----
// Motor command ramp limiter (setpoint slew-rate limiter) in Q2.14 fixed point.
// Each command beat on req_port gives exactly one result beat on rsp_port carrying the
// drive value, the ramp target, the per-tick step and the ready-for-new-ramp flag.
// Commands: update (cmd 0) moves the drive toward the value, override (cmd 1) forces
// drive and target. Epsilon, max_delta and ticks_to_target are set through the APB
// port at byte addresses 0, 4 and 8, and should be written only while the block is idle.
// One command is in flight at a time. An update that starts a new ramp passes from
// acceptance through evaluation, the one-bit-per-cycle step divider and the step
// update to the result beat; every other command goes from evaluation straight to
// the result beat. The next command is accepted the cycle after the result is loaded
// into the output register, so it may still wait there while the next one is worked on.
// If the receiver stalls, the result holds in the output register and the next
// result waits until that slot is free; meanwhile req_port.ready stays low.
// Synchronous reset clears drive, target, step and tick count, sets the ready flag and
// restores the register defaults (164, 8192, 10). No result is pending after reset.
// Depends on rmpl_pkg, rmpl_req_if, rmpl_rsp_if, rmpl_csr, rmpl_ctrl, rmpl_datapath.
`timescale 1ns / 1ps

module motor_command_ramp_limiter_unit
   import rmpl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rmpl_req_if.sink              req_port,
   rmpl_rsp_if.source            rsp_port,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   rmpl_cfg_type    cfg;
   rmpl_ctrl_type   ctrl;
   rmpl_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   logic signed [15:0] rsp_drive_value;
   logic signed [15:0] rsp_target_value;
   logic signed [16:0] rsp_step_delta;
   logic               rsp_jump_ready;

   rmpl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rmpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   rmpl_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .ctrl             (ctrl),
      .status           (status),
      .req_cmd          (req_port.cmd),
      .req_value        (req_port.value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_port.ready),
      .rsp_drive_value  (rsp_drive_value),
      .rsp_target_value (rsp_target_value),
      .rsp_step_delta   (rsp_step_delta),
      .rsp_jump_ready   (rsp_jump_ready)
   );

   assign req_port.ready        = req_ready;
   assign rsp_port.valid        = rsp_valid;
   assign rsp_port.drive_value  = rsp_drive_value;
   assign rsp_port.target_value = rsp_target_value;
   assign rsp_port.step_delta   = rsp_step_delta;
   assign rsp_port.jump_ready   = rsp_jump_ready;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for motor_command_ramp_limiter_unit: a directed table of command
// beats, then random ramp sequences under several register settings and idling profiles.
// Depends on rmpl_pkg, rmpl_req_if, rmpl_rsp_if and the unit's RTL.
`timescale 1ns / 1ps

module testbench
   import rmpl_pkg::*;
();

   localparam int   NUM_PHASES     = 7;
   localparam int   WATCHDOG_LIMIT = 2000;
   localparam int   SETTLE_CYCLES  = 40;
   localparam int   MAX_REPORTS    = 10;

   typedef struct packed {
      logic signed [15:0] drive;
      logic signed [15:0] target;
      logic signed [16:0] step;
      logic               ready;
   } ramp_result_type;

   typedef struct {
      logic               cmd;
      logic signed [15:0] value;
      bit                 typed;
      ramp_result_type    result;
   } command_row_type;

   typedef struct {
      rmpl_cfg_type settings;
      int           items;
   } phase_plan_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rmpl_req_if req_bus ();
   rmpl_rsp_if rsp_bus ();

   motor_command_ramp_limiter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Ramp model state, kept in step with every accepted command beat.
   rmpl_cfg_type model_cfg;
   int           model_drive;
   int           model_target;
   int           model_step;
   int           model_ticks_done;
   bit           model_ready;

   ramp_result_type expected_results[$];
   command_row_type directed_rows[$];
   phase_plan_type  phase_plan[NUM_PHASES];

   int send_idle_pct;
   int recv_stall_pct;
   int failure_count;
   int result_beats;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void report_failure(input string message);
      failure_count += 1;
      if (failure_count <= MAX_REPORTS) begin
         $display("%s", message);
      end
   endfunction

   function automatic int clamp_to_unit(input int x);
      int r;
      r = x;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
   endfunction

   function automatic ramp_result_type predict_tick(input logic c,
                                                    input logic signed [15:0] raw);
      int              v;
      int              distance;
      int              move;
      int              limit;
      int              divisor;
      ramp_result_type r;
      v = clamp_to_unit(int'(raw));
      if (c == CMD_OVERRIDE) begin
         model_drive      = v;
         model_target     = v;
         model_ready      = 1'b1;
         model_ticks_done = 0;
      end else begin
         distance = v - model_drive;
         if (distance < 0) distance = -distance;
         if (distance < int'(model_cfg.epsilon)) begin
            model_drive = v;
            model_ready = 1'b1;
         end else if (model_ready) begin
            move    = v - model_target;
            limit   = int'(model_cfg.max_delta);
            divisor = (model_cfg.ticks == 8'd0) ? 1 : int'(model_cfg.ticks);
            if (move > limit) move = limit;
            if (move < -limit) move = -limit;
            model_target     = clamp_to_unit(model_target + move);
            // Integer division truncates toward zero, as the step requires.
            model_step       = (model_target - model_drive) / divisor;
            model_ready      = 1'b0;
            model_ticks_done = 0;
         end else if (model_ticks_done < int'(model_cfg.ticks)) begin
            model_drive      = clamp_to_unit(model_drive + model_step);
            model_ticks_done += 1;
         end else begin
            model_ready = 1'b1;
         end
      end
      r.drive  = model_drive[15:0];
      r.target = model_target[15:0];
      r.step   = model_step[16:0];
      r.ready  = model_ready;
      return r;
   endfunction

   task automatic send_tick(input logic c, input logic signed [15:0] v, input bit typed,
                            input ramp_result_type typed_result);
      ramp_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= c;
      req_bus.value <= v;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      predicted = predict_tick(c, v);
      expected_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // Back-to-back APB transfers: the next setup phase follows the access phase directly,
   // so psel and penable are only released by the caller once all transfers are done.
   task automatic csr_access(input logic write, input logic [1:0] index,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] readback;
      csr_access(1'b1, index, value, readback);
      csr_access(1'b0, index, 32'd0, readback);
      if (readback !== value) begin
         report_failure($sformatf("register %0d reads %0h, expected %0h",
                                  index, readback, value));
      end
      case (index)
         CSR_EPSILON:   model_cfg.epsilon   = value[14:0];
         CSR_MAX_DELTA: model_cfg.max_delta = value[14:0];
         CSR_TICKS:     model_cfg.ticks     = value[7:0];
         default: ;
      endcase
   endtask

   task automatic run_random(input int count);
      logic signed [15:0] held;
      logic signed [15:0] v;
      logic               c;
      int                 burst_left;
      int                 pick;
      int                 span;
      int                 near;
      int                 pause_at;
      burst_left = 0;
      held       = '0;
      pause_at   = $urandom_range(3 * count / 4, count / 4);
      for (int n = 0; n < count; n++) begin
         if (n == pause_at) drain_results();
         if (burst_left == 0) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
               held = 16'($urandom_range(65535));
            end else if (pick < 30) begin
               case ($urandom_range(3))
                  0:       held = 16'sd16384;
                  1:       held = -16'sd16384;
                  2:       held = 16'sh7FFF;
                  default: held = 16'sh8000;
               endcase
            end else begin
               held = 16'(int'($urandom_range(32768)) - 16384);
            end
            // Long enough, most of the time, for the ramp towards it to run out.
            burst_left = $urandom_range(int'(model_cfg.ticks) + 3, 1);
         end
         pick = $urandom_range(99);
         c    = CMD_UPDATE;
         if (pick < 8) begin
            c = CMD_OVERRIDE;
            v = ($urandom_range(1) == 0) ? 16'($urandom_range(65535))
                                         : 16'(int'($urandom_range(32768)) - 16384);
         end else if (pick < 20) begin
            // Around the pass-through band of the present drive value.
            span = int'(model_cfg.epsilon) + 2;
            near = model_drive + int'($urandom_range(2 * span)) - span;
            if (near > 32767) near = 32767;
            if (near < -32768) near = -32768;
            v = near[15:0];
         end else if (pick < 25) begin
            v = 16'($urandom_range(65535));
         end else begin
            v = held;
            burst_left -= 1;
         end
         send_tick(c, v, 1'b0, '0);
      end
   endtask

   // Result side: random stalls, each beat compared with the oldest expectation.
   initial begin
      ramp_result_type seen;
      ramp_result_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            seen = '{rsp_bus.drive_value, rsp_bus.target_value, rsp_bus.step_delta,
                     rsp_bus.jump_ready};
            result_beats += 1;
            if (expected_results.size() == 0) begin
               report_failure($sformatf("beat %0d: unexpected result drive %0d target %0d",
                                        result_beats, seen.drive, seen.target));
            end else begin
               want = expected_results.pop_front();
               if (seen.drive !== want.drive || seen.target !== want.target ||
                   seen.step !== want.step || seen.ready !== want.ready) begin
                  report_failure($sformatf(
                     "beat %0d: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b (drv/tgt/stp/rdy)",
                     result_beats, want.drive, want.target, want.step, want.ready,
                     seen.drive, seen.target, seen.step, seen.ready));
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles += 1;
         end
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd   = CMD_UPDATE;
      req_bus.value = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      failure_count = 0;
      result_beats  = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;

      model_cfg        = '{EPSILON_RESET, MAX_DELTA_RESET, TICKS_RESET};
      model_drive      = 0;
      model_target     = 0;
      model_step       = 0;
      model_ticks_done = 0;
      model_ready      = 1'b1;

      phase_plan[0] = '{'{15'd164, 15'd8192, 8'd10}, 120};
      phase_plan[1] = '{'{15'd0, 15'd32767, 8'd1}, 120};
      phase_plan[2] = '{'{15'd32767, 15'd0, 8'd7}, 100};
      phase_plan[3] = '{'{15'd164, 15'd8192, 8'd0}, 120};
      phase_plan[4] = '{'{15'd300, 15'd2000, 8'd255}, 300};
      phase_plan[5] = '{'{15'd1, 15'd16384, 8'd3}, 120};
      phase_plan[6] = '{'{15'd5000, 15'd700, 8'd20}, 120};

      // Directed table, run with the register values left by reset.
      directed_rows.push_back('{CMD_UPDATE, 16'sd100, 1'b1, '{16'sd100, 16'sd0, 17'sd0, 1'b1}});
      directed_rows.push_back('{CMD_UPDATE, 16'sd163, 1'b1, '{16'sd163, 16'sd0, 17'sd0, 1'b1}});
      directed_rows.push_back('{CMD_OVERRIDE, 16'sh7FFF, 1'b1,
                                '{16'sd16384, 16'sd16384, 17'sd0, 1'b1}});
      directed_rows.push_back('{CMD_OVERRIDE, 16'sh8000, 1'b1,
                                '{-16'sd16384, -16'sd16384, 17'sd0, 1'b1}});
      directed_rows.push_back('{CMD_OVERRIDE, -16'sd16385, 1'b1,
                                '{-16'sd16384, -16'sd16384, 17'sd0, 1'b1}});
      directed_rows.push_back('{CMD_UPDATE, 16'sd16384, 1'b1,
                                '{-16'sd16384, -16'sd8192, 17'sd819, 1'b0}});
      // Ten ramp steps, the tick that restores ready, and the next ramp.
      for (int i = 0; i < 12; i++) begin
         directed_rows.push_back('{CMD_UPDATE, 16'sd16384, 1'b0, '0});
      end
      directed_rows.push_back('{CMD_OVERRIDE, 16'sd0, 1'b0, '0});
      directed_rows.push_back('{CMD_UPDATE, 16'sd164, 1'b0, '0});
      directed_rows.push_back('{CMD_UPDATE, -16'sd200, 1'b0, '0});
      directed_rows.push_back('{CMD_OVERRIDE, 16'sd16384, 1'b0, '0});
      directed_rows.push_back('{CMD_UPDATE, 16'sd16220, 1'b0, '0});
      directed_rows.push_back('{CMD_UPDATE, 16'sd16221, 1'b0, '0});
      directed_rows.push_back('{CMD_UPDATE, -16'sd16384, 1'b0, '0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_tick(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed,
                   directed_rows[i].result);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            drain_results();
            write_register(CSR_EPSILON, 32'(phase_plan[p].settings.epsilon));
            write_register(CSR_MAX_DELTA, 32'(phase_plan[p].settings.max_delta));
            write_register(CSR_TICKS, 32'(phase_plan[p].settings.ticks));
            csr_psel    <= 1'b0;
            csr_penable <= 1'b0;
         end
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         run_random(phase_plan[p].items);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failure_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
